// ----- rtl/nfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfs_pkg
// Shared constants and types for the NEH flow-shop scheduler.
// ----------------------------------------------------------------------------
package nfs_pkg;

    localparam int DEF_MAX_TASKS    = 32;
    localparam int DEF_MAX_MACHINES = 16;
    localparam int DEF_TIME_BITS    = 8;

    localparam int TASK_ID_W = 5;
    localparam int SPAN_W    = 18;
    localparam int NT_W      = 6;
    localparam int NM_W      = 5;
    localparam int ADDR_W    = 3;

    localparam logic [ADDR_W-1:0] REG_NUM_TASKS    = 3'd0;
    localparam logic [ADDR_W-1:0] REG_NUM_MACHINES = 3'd4;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_WSUM,
        ST_SORT,
        ST_INS_INIT,
        ST_EVAL_CLR,
        ST_EVAL_RD,
        ST_EVAL_ACC,
        ST_EVAL_END,
        ST_INS_SHIFT,
        ST_EMIT
    } nfs_state_t;

endpackage

// ----- rtl/nfs_time_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfs_time_mem
// Processing time store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nfs_time_mem #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/neh_flow_shop_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neh_flow_shop_scheduler
// Loads a flow-shop instance and orders its tasks by the NEH heuristic.
// ----------------------------------------------------------------------------
//  channel   | handshake                       | payload
//  request   | start, busy                     | proc_time, last_time
//  result    | done                            | task_id, makespan, last_in_order
//  config    | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
//  A request without last_time only writes the time store. A last_time request
//  starts scheduling: weight sums, a bubble sort by weight, then each candidate
//  evaluation through one shared max-plus-add unit fed by the single read port
//  of the time store, over all positions and insertions. Each insertion adds
//  a setup state and shift steps from i down to best_pos. Results then follow,
//  one per cycle, n of them. The result side cannot stall. No clearing pass at
//  reset.
// ----------------------------------------------------------------------------
module neh_flow_shop_scheduler
    import nfs_pkg::*;
#(
    parameter int MAX_TASKS    = DEF_MAX_TASKS,
    parameter int MAX_MACHINES = DEF_MAX_MACHINES,
    parameter int TIME_BITS    = DEF_TIME_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [TIME_BITS-1:0]        proc_time,
    input  logic                        last_time,
    output logic                        done,
    output logic [nfs_pkg::TASK_ID_W-1:0] task_id,
    output logic [nfs_pkg::SPAN_W-1:0]  makespan,
    output logic                        last_in_order,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nfs_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    localparam int DEPTH = MAX_TASKS * MAX_MACHINES;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(MAX_TASKS);
    localparam int CW    = $clog2(MAX_TASKS + 1);
    localparam int MW    = $clog2(MAX_MACHINES + 1);
    localparam int JW    = $clog2(MAX_MACHINES + 1);
    localparam int WW    = TIME_BITS + $clog2(MAX_MACHINES + 1);
    localparam int LW    = TIME_BITS + $clog2(MAX_TASKS + MAX_MACHINES) + 1;

    // configuration
    logic [NT_W-1:0] num_tasks_reg;
    logic [NM_W-1:0] num_machines_reg;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_tasks_reg    <= NT_W'(32);
            num_machines_reg <= NM_W'(16);
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                REG_NUM_TASKS:    num_tasks_reg    <= pwdata[NT_W-1:0];
                REG_NUM_MACHINES: num_machines_reg <= pwdata[NM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_NUM_TASKS:    prdata = 32'(num_tasks_reg);
            REG_NUM_MACHINES: prdata = 32'(num_machines_reg);
            default:          prdata = '0;
        endcase
    end

    // clamped sizes
    logic [CW-1:0] n_val;
    logic [MW-1:0] m_val;
    always_comb
    begin
        if (num_tasks_reg == '0)
            n_val = CW'(1);
        else if (32'(num_tasks_reg) > MAX_TASKS)
            n_val = CW'(MAX_TASKS);
        else
            n_val = CW'(num_tasks_reg);
        if (num_machines_reg == '0)
            m_val = MW'(1);
        else if (32'(num_machines_reg) > MAX_MACHINES)
            m_val = MW'(MAX_MACHINES);
        else
            m_val = MW'(num_machines_reg);
    end

    // state
    nfs_state_t state_reg, state_next;
    logic [AW-1:0] load_reg;
    logic [AW-1:0] addr_reg;      // running store address
    logic [CW-1:0] i_reg;         // outer index
    logic [CW-1:0] k_reg;         // inner index / position
    logic [CW-1:0] p_reg;         // candidate position
    logic [CW-1:0] s_reg;         // sequence index in evaluation
    logic [JW-1:0] j_reg;         // machine index
    logic [WW-1:0] acc_reg;
    logic [LW-1:0] best_reg;
    logic [CW-1:0] best_pos_reg;
    logic [TW-1:0] ins_task_reg;
    logic [TW-1:0]  order_reg  [MAX_TASKS];
    logic [WW-1:0]  weight_reg [MAX_TASKS];
    logic [LW-1:0]  crow_reg   [MAX_MACHINES+1];
    logic          final_reg;
    logic [LW-1:0] span_reg;

    // memory
    logic           mem_we;
    logic [AW-1:0]  mem_raddr;
    logic [TIME_BITS-1:0] mem_rdata;

    nfs_time_mem #(.DEPTH(DEPTH), .WIDTH(TIME_BITS)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (load_reg),
        .wdata (proc_time),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    logic accept;
    assign accept = start && !busy;
    assign mem_we = accept;

    // task at sequence index s of the current candidate
    logic [TW-1:0] cand_task;
    always_comb
    begin
        if (s_reg < p_reg)
            cand_task = order_reg[s_reg[TW-1:0]];
        else if (s_reg == p_reg)
            cand_task = ins_task_reg;
        else
            cand_task = order_reg[TW'(s_reg - CW'(1))];
    end

    logic [AW-1:0] row_base;
    assign row_base = AW'(32'(cand_task) * 32'(m_val));

    // read address: weights walk linearly, evaluation uses the candidate row
    always_comb
    begin
        if (state_reg == ST_EVAL_RD)
            mem_raddr = AW'(row_base + AW'(j_reg) - AW'(1));
        else
            mem_raddr = addr_reg;
    end

    // shared max-plus-add unit
    logic [LW-1:0] mx, cr_sum;
    always_comb
    begin
        mx = (crow_reg[j_reg] > crow_reg[JW'(j_reg - JW'(1))]) ?
             crow_reg[j_reg] : crow_reg[JW'(j_reg - JW'(1))];
        cr_sum = mx + LW'(mem_rdata);
    end

    // weight-sum pipeline: each read is issued in the cycle before its data is summed
    logic          wvalid_reg;
    logic [TW-1:0] wtask_reg;
    logic          wfirst_reg;

    logic last_j, last_s, sort_swap;
    assign last_j = (j_reg == JW'(m_val));
    assign last_s = (s_reg == i_reg);
    assign sort_swap = weight_reg[k_reg[TW-1:0]] < weight_reg[TW'(k_reg + CW'(1))];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
                if (accept && last_time)
                    state_next = ST_WSUM;
            ST_WSUM:
                if (wvalid_reg && wtask_reg == TW'(n_val - CW'(1)) && addr_reg == '0
                    && !wfirst_reg)
                    state_next = (n_val == CW'(1)) ? ST_INS_INIT : ST_SORT;
            ST_SORT:
                if (k_reg == n_val - CW'(2) && i_reg == n_val - CW'(2))
                    state_next = ST_INS_INIT;
            ST_INS_INIT:
                state_next = (i_reg == n_val) ? ST_EVAL_CLR : ST_EVAL_CLR;
            ST_EVAL_CLR:
                state_next = ST_EVAL_RD;
            ST_EVAL_RD:
                state_next = ST_EVAL_ACC;
            ST_EVAL_ACC:
                if (last_j && last_s)
                    state_next = ST_EVAL_END;
                else
                    state_next = ST_EVAL_RD;
            ST_EVAL_END:
                if (final_reg)
                    state_next = ST_EMIT;
                else if (p_reg == i_reg)
                    state_next = ST_INS_SHIFT;
                else
                    state_next = ST_EVAL_CLR;
            ST_INS_SHIFT:
                if (k_reg == best_pos_reg)
                    state_next = ST_INS_INIT;
            ST_EMIT:
                if (k_reg == n_val - CW'(1))
                    state_next = ST_LOAD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            load_reg  <= '0;
            wvalid_reg <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                load_reg <= last_time ? '0 : AW'(32'(load_reg) + 1);
            if (state_reg == ST_LOAD && accept && last_time)
                wvalid_reg <= 1'b0;
            else if (state_reg == ST_WSUM)
                wvalid_reg <= 1'b1;
            if (state_reg == ST_INS_INIT)
                final_reg <= (i_reg == n_val);
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_LOAD:
            begin
                addr_reg   <= '0;
                j_reg      <= '0;
                wtask_reg  <= '0;
                wfirst_reg <= 1'b1;
                acc_reg    <= '0;
                for (int t = 0; t < MAX_TASKS; t++)
                    order_reg[t] <= TW'(t);
            end
            ST_WSUM:
            begin
                // mem_rdata holds the entry addressed last cycle
                if (wvalid_reg)
                begin
                    if (j_reg == JW'(m_val - MW'(1)))
                    begin
                        weight_reg[wtask_reg] <= acc_reg + WW'(mem_rdata);
                        acc_reg   <= '0;
                        j_reg     <= '0;
                        wtask_reg <= TW'(wtask_reg + TW'(1));
                    end
                    else
                    begin
                        acc_reg <= acc_reg + WW'(mem_rdata);
                        j_reg   <= JW'(j_reg + JW'(1));
                    end
                end
                wfirst_reg <= 1'b0;
                if (32'(addr_reg) + 1 == 32'(n_val) * 32'(m_val))
                    addr_reg <= '0;
                else
                    addr_reg <= AW'(32'(addr_reg) + 1);
                i_reg <= '0;
                k_reg <= '0;
            end
            ST_SORT:
            begin
                if (sort_swap)
                begin
                    weight_reg[k_reg[TW-1:0]]       <= weight_reg[TW'(k_reg + CW'(1))];
                    weight_reg[TW'(k_reg + CW'(1))] <= weight_reg[k_reg[TW-1:0]];
                    order_reg[k_reg[TW-1:0]]        <= order_reg[TW'(k_reg + CW'(1))];
                    order_reg[TW'(k_reg + CW'(1))]  <= order_reg[k_reg[TW-1:0]];
                end
                if (state_next == ST_INS_INIT)
                begin
                    k_reg <= '0;
                    i_reg <= '0;
                end
                else if (k_reg == n_val - CW'(2))
                begin
                    k_reg <= '0;
                    i_reg <= CW'(i_reg + CW'(1));
                end
                else
                    k_reg <= CW'(k_reg + CW'(1));
            end
            ST_INS_INIT:
            begin
                // final pass evaluates the finished order once, as position i
                p_reg        <= (i_reg == n_val) ? CW'(n_val - CW'(1)) : '0;
                best_reg     <= '1;
                best_pos_reg <= '0;
                if (i_reg != n_val)
                    ins_task_reg <= order_reg[i_reg[TW-1:0]];
                else
                begin
                    ins_task_reg <= order_reg[TW'(n_val - CW'(1))];
                    i_reg        <= CW'(n_val - CW'(1));
                end
            end
            ST_EVAL_CLR:
            begin
                for (int c = 0; c <= MAX_MACHINES; c++)
                    crow_reg[c] <= '0;
                s_reg <= '0;
                j_reg <= JW'(1);
            end
            ST_EVAL_RD:
            begin
                // wait for registered read
            end
            ST_EVAL_ACC:
            begin
                crow_reg[j_reg] <= cr_sum;
                if (last_j)
                begin
                    j_reg <= JW'(1);
                    s_reg <= CW'(s_reg + CW'(1));
                    if (last_s)
                        span_reg <= cr_sum;
                end
                else
                    j_reg <= JW'(j_reg + JW'(1));
            end
            ST_EVAL_END:
            begin
                if (span_reg < best_reg)
                begin
                    best_reg     <= span_reg;
                    best_pos_reg <= p_reg;
                end
                p_reg <= CW'(p_reg + CW'(1));
                k_reg <= final_reg ? '0 : i_reg;
            end
            ST_INS_SHIFT:
            begin
                // move entries up from i down to best_pos, then drop task in
                if (k_reg == best_pos_reg)
                begin
                    order_reg[k_reg[TW-1:0]] <= ins_task_reg;
                    i_reg <= CW'(i_reg + CW'(1));
                end
                else
                begin
                    order_reg[k_reg[TW-1:0]] <= order_reg[TW'(k_reg - CW'(1))];
                    k_reg <= CW'(k_reg - CW'(1));
                end
            end
            ST_EMIT:
                k_reg <= CW'(k_reg + CW'(1));
            default: ;
        endcase
    end

    // outputs
    always_comb
    begin
        busy          = (state_reg != ST_LOAD);
        done          = (state_reg == ST_EMIT);
        task_id       = TASK_ID_W'(order_reg[k_reg[TW-1:0]]);
        makespan      = (span_reg > LW'(2**SPAN_W - 1)) ? '1 : SPAN_W'(span_reg);
        last_in_order = (k_reg == n_val - CW'(1));
    end

    // assertions
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("result strobe while idle");
    a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
        (done && last_in_order) |=> !busy) else $error("no return to load");
    a_load_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_time) |=> (load_reg == '0)) else $error("load count not cleared");
endmodule
